### rtl/skts_pkg.sv
// Shared definitions for the sorted key table: default sizes, transaction field
// widths and result status codes. No dependencies.
package skts_pkg;

  localparam int DefCapacity = 256;
  localparam int DefKeyBits  = 16;

  // Fixed port widths of the transaction fields.
  localparam int KeyW     = 16;
  localparam int StatusW  = 3;
  localparam int PosW     = 8;
  localparam int ProbesW  = 4;
  localparam int ShiftW   = 8;

  typedef logic [StatusW-1:0] status_t;

  localparam status_t ST_FOUND    = 3'd0;
  localparam status_t ST_MISSING  = 3'd1;
  localparam status_t ST_PRESENT  = 3'd2;
  localparam status_t ST_INSERTED = 3'd3;
  localparam status_t ST_FULL     = 3'd4;

endpackage

### rtl/skts_store.sv
// Key storage of the sorted key table: one write port and one read port
// with registered read data. No package dependencies.
module skts_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // The user must keep read and write off the same cell in the same cycle; the store itself does not enforce it.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sorted_key_table_search_insert.sv
// Sorted key table with binary-search lookup and ordered insert.
// Depends on skts_pkg and skts_store.
//
//   channel  signals                                                        direction
//   input    in_valid_i, in_stall_o, kind_i, key_i                          into block
//   output   out_valid_o, out_stall_i, status_o, position_o, probes_o, shifted_o  out of block
//
// One transaction at a time: the input stalls until its result is loaded into
// the output register, and a result held under out_stall_i keeps the next one waiting.
// Each binary-search probe addresses the store in S_PROBE and compares the read data in S_CMP.
// Inserting a new key moves the entries at and above the insertion point up one cell
// (S_SHPRIME, then S_SHMOVE per entry), then writes the key in S_WRKEY, directly when nothing shifts.
// Reset clears the entry count; the store itself is not cleared.
module sorted_key_table_search_insert #(
  parameter int CAPACITY = skts_pkg::DefCapacity,
  parameter int KEY_BITS = skts_pkg::DefKeyBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [skts_pkg::KeyW-1:0]     key_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output skts_pkg::status_t             status_o,
  output logic [skts_pkg::PosW-1:0]     position_o,
  output logic [skts_pkg::ProbesW-1:0]  probes_o,
  output logic [skts_pkg::ShiftW-1:0]   shifted_o
);
  import skts_pkg::*;

  localparam int AddrW   = $clog2(CAPACITY);
  localparam int CntW    = $clog2(CAPACITY + 1);
  localparam int ProbeW  = $clog2(AddrW + 2);
  localparam int KeyInW  = (KEY_BITS < KeyW) ? KEY_BITS : KeyW;

  localparam int StW = 3;
  localparam logic [StW-1:0] S_IDLE    = 3'd0;
  localparam logic [StW-1:0] S_PROBE   = 3'd1;
  localparam logic [StW-1:0] S_CMP     = 3'd2;
  localparam logic [StW-1:0] S_SHPRIME = 3'd3;
  localparam logic [StW-1:0] S_SHMOVE  = 3'd4;
  localparam logic [StW-1:0] S_WRKEY   = 3'd5;
  localparam logic [StW-1:0] S_DONE    = 3'd6;

  logic [StW-1:0]      state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q, out_valid_d;

  logic                kind_q, kind_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CntW-1:0]     lo_q, lo_d;
  logic [CntW-1:0]     hi_q, hi_d;   // exclusive upper bound
  logic [AddrW-1:0]    mid_q, mid_d;
  logic [CntW-1:0]     ptr_q, ptr_d;
  logic [ProbeW-1:0]   probes_q, probes_d;
  status_t             res_status_q, res_status_d;
  logic [AddrW-1:0]    res_pos_q, res_pos_d;
  logic [CntW-1:0]     res_shift_q, res_shift_d;

  status_t             out_status_q, out_status_d;
  logic [PosW-1:0]     out_pos_q, out_pos_d;
  logic [ProbesW-1:0]  out_probes_q, out_probes_d;
  logic [ShiftW-1:0]   out_shift_q, out_shift_d;

  logic [KEY_BITS-1:0] key_in;
  logic [CntW:0]       mid_sum;
  logic [AddrW-1:0]    mid_calc;
  logic [CntW-1:0]     ptr_m1, ptr_m2;

  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic [AddrW-1:0]    mem_raddr;
  logic [KEY_BITS-1:0] mem_rdata;

  assign key_in   = KEY_BITS'(key_i[KeyInW-1:0]);
  assign mid_sum  = (CntW+1)'(lo_q) + (CntW+1)'(hi_q) - (CntW+1)'(1);
  assign mid_calc = mid_sum[AddrW:1];
  assign ptr_m1   = ptr_q - CntW'(1);
  assign ptr_m2   = ptr_q - CntW'(2);

  skts_store #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    kind_d       = kind_q;
    key_d        = key_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    ptr_d        = ptr_q;
    probes_d     = probes_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_shift_d  = res_shift_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_probes_d = out_probes_q;
    out_shift_d  = out_shift_q;
    mem_we       = 1'b0;
    mem_waddr    = lo_q[AddrW-1:0];
    mem_wdata    = key_q;
    mem_raddr    = mid_calc;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = kind_i;
          key_d    = key_in;
          lo_d     = '0;
          hi_d     = count_q;
          probes_d = '0;
          state_d  = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_calc;
          state_d = S_CMP;
        end else begin
          // Search ended without a hit; lo_q is the insertion point.
          res_pos_d   = '0;
          res_shift_d = '0;
          if (!kind_q) begin
            res_status_d = ST_MISSING;
            state_d      = S_DONE;
          end else if (count_q == CntW'(CAPACITY)) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            res_status_d = ST_INSERTED;
            res_pos_d    = lo_q[AddrW-1:0];
            res_shift_d  = count_q - lo_q;
            ptr_d        = count_q;
            state_d      = (count_q == lo_q) ? S_WRKEY : S_SHPRIME;
          end
        end
      end
      S_CMP: begin
        probes_d = probes_q + ProbeW'(1);
        if (mem_rdata == key_q) begin
          res_status_d = kind_q ? ST_PRESENT : ST_FOUND;
          res_pos_d    = mid_q;
          res_shift_d  = '0;
          state_d      = S_DONE;
        end else begin
          if (mem_rdata < key_q) begin
            lo_d = CntW'(mid_q) + CntW'(1);
          end else begin
            hi_d = CntW'(mid_q);
          end
          state_d = S_PROBE;
        end
      end
      S_SHPRIME: begin
        mem_raddr = ptr_m1[AddrW-1:0];
        state_d   = S_SHMOVE;
      end
      S_SHMOVE: begin
        // Write the entry read last cycle one cell up, and read the next one.
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AddrW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = ptr_m2[AddrW-1:0];
        ptr_d     = ptr_m1;
        if (ptr_m1 == lo_q) begin
          state_d = S_WRKEY;
        end
      end
      S_WRKEY: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AddrW-1:0];
        mem_wdata = key_q;
        count_d   = count_q + CntW'(1);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = PosW'(res_pos_q);
          out_probes_d = ProbesW'(probes_q);
          out_shift_d  = ShiftW'(res_shift_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    ptr_q        <= ptr_d;
    probes_q     <= probes_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_shift_q  <= res_shift_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_probes_q <= out_probes_d;
    out_shift_q  <= out_shift_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = out_pos_q;
  assign probes_o    = out_probes_q;
  assign shifted_o   = out_shift_q;

endmodule

### sim/tb_sorted_key_table_search_insert.sv
// Testbench for sorted_key_table_search_insert: a local copy of the sorted key
// table predicts each result, and randomized handshakes drive lookups and inserts.
// Depends on skts_pkg and the block's RTL.
module tb_sorted_key_table_search_insert;
  import skts_pkg::*;

  localparam int Capacity   = DefCapacity;
  localparam int IdleLimit  = 4000;
  localparam int SettleWait = 300;
  localparam int MaxReports = 10;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    status_t              status;
    logic [PosW-1:0]      position;
    logic [ProbesW-1:0]   probes;
    logic [ShiftW-1:0]    shifted;
  } table_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = OP_LOOKUP;
  logic [KeyW-1:0]    key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  status_t            status;
  logic [PosW-1:0]    position;
  logic [ProbesW-1:0] probes;
  logic [ShiftW-1:0]  shifted;

  // Local copy of the sorted table, updated as each transaction is accepted.
  logic [KeyW-1:0] key_table [Capacity];
  int              table_count = 0;

  table_result_t   pending_results [$];
  int              mismatches = 0;
  bit              no_gaps = 1'b0;
  int              hold_left = 0;

  sorted_key_table_search_insert DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .key_i       (key),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .position_o  (position),
    .probes_o    (probes),
    .shifted_o   (shifted)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic table_result_t search_and_insert(logic op, logic [KeyW-1:0] k);
    int            lo;
    int            hi;
    int            mid;
    int            n;
    bit            hit;
    table_result_t r;
    lo  = 0;
    hi  = table_count - 1;
    mid = 0;
    n   = 0;
    hit = 1'b0;
    r   = '0;
    while (lo <= hi && !hit) begin
      mid = (lo + hi) / 2;
      n++;
      if (key_table[mid] == k) hit = 1'b1;
      else if (key_table[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    r.probes = n[ProbesW-1:0];
    if (op == OP_LOOKUP) begin
      r.status   = hit ? ST_FOUND : ST_MISSING;
      r.position = hit ? mid[PosW-1:0] : '0;
    end else if (hit) begin
      r.status   = ST_PRESENT;
      r.position = mid[PosW-1:0];
    end else if (table_count >= Capacity) begin
      r.status = ST_FULL;
    end else begin
      for (int i = table_count; i > lo; i--) key_table[i] = key_table[i-1];
      key_table[lo] = k;
      n         = table_count - lo;
      r.shifted = n[ShiftW-1:0];
      table_count++;
      r.status   = ST_INSERTED;
      r.position = lo[PosW-1:0];
    end
    return r;
  endfunction

  // Favors keys already in the table and their neighbors so that hits, duplicate
  // inserts and inserts between close keys are common.
  function automatic logic [KeyW-1:0] pick_key();
    int              sel;
    logic [KeyW-1:0] k;
    sel = $urandom_range(0, 9);
    if (table_count > 0 && sel < 4) begin
      k = key_table[$urandom_range(0, table_count - 1)];
    end else if (table_count > 0 && sel < 6) begin
      k = key_table[$urandom_range(0, table_count - 1)];
      k = (sel == 4) ? k + 1'b1 : k - 1'b1;
    end else if (sel == 6) begin
      k = $urandom_range(0, 1) ? '0 : '1;
    end else begin
      k = KeyW'($urandom_range(0, 65535));
    end
    return k;
  endfunction

  // Valid is left high after acceptance; the next call either keeps it high
  // with new values or lowers it for the drawn gap.
  task automatic send_item(logic op, logic [KeyW-1:0] k);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op;
    key      <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(search_and_insert(op, k));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin : result_checker
    int            wait_left;
    table_result_t want;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result: status %0d position %0d probes %0d shifted %0d",
                     status, position, probes, shifted);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status || position !== want.position ||
              probes !== want.probes || shifted !== want.shifted) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch: expected status %0d position %0d probes %0d shifted %0d, %s",
                       want.status, want.position, want.probes, want.shifted,
                       $sformatf("got %0d %0d %0d %0d", status, position, probes, shifted));
          end
        end
        wait_left = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_empty_table();
    send_item(OP_LOOKUP, 16'h0000);
    send_item(OP_LOOKUP, 16'hFFFF);
    send_item(OP_LOOKUP, 16'h1234);
  endtask

  task automatic test_directed_keys();
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'hAAAA);
    send_item(OP_INSERT, 16'h5555);
    send_item(OP_INSERT, 16'h0001);
    send_item(OP_LOOKUP, 16'h0000);
    send_item(OP_LOOKUP, 16'hFFFF);
    send_item(OP_LOOKUP, 16'h8001);
    send_item(OP_LOOKUP, 16'h5555);
    send_item(OP_INSERT, 16'hFFFE);
    send_item(OP_INSERT, 16'h7FFF);
    send_item(OP_LOOKUP, 16'h0002);
  endtask

  // The receiver holds off while items keep coming, so the input stalls;
  // afterwards the sender waits for every outstanding result.
  task automatic test_output_backpressure();
    hold_left = 400;
    no_gaps   = 1'b1;
    repeat (6) send_item($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, pick_key());
    no_gaps = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic(int n_items);
    logic op;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      op = ($urandom_range(0, 99) < 15) ? OP_INSERT : OP_LOOKUP;
      send_item(op, pick_key());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_full_table();
    logic [KeyW-1:0] k;
    int              i;
    bit              used_gap;
    used_gap = 1'b0;
    while (table_count < Capacity) begin
      if (table_count == Capacity - 1 && !used_gap) begin
        // Insert just above the lowest run of keys so that nearly all entries shift.
        i = 0;
        while (i + 1 < table_count && key_table[i+1] == key_table[i] + 1'b1) i++;
        k        = key_table[i] + 1'b1;
        used_gap = 1'b1;
      end else begin
        k = KeyW'($urandom_range(0, 65535));
      end
      send_item(OP_INSERT, k);
    end
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_LOOKUP, key_table[Capacity-1]);
    send_item(OP_LOOKUP, key_table[0]);
    repeat (100) send_item($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, pick_key());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_directed_keys();
    test_output_backpressure();
    test_random_traffic(1700);
    test_full_table();
    drain_results();
    repeat (SettleWait) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sorted_key_table_search_insert.f
rtl/skts_pkg.sv
rtl/skts_store.sv
rtl/sorted_key_table_search_insert.sv
sim/tb_sorted_key_table_search_insert.sv
